// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/tmlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlc_pkg
// Shared types, constants and small helpers of the mip layout calculator.
// ----------------------------------------------------------------------------
package tmlc_pkg;

  localparam logic [3:0] MAX_LEVELS = 4'd15;

  // configuration register indexes
  localparam logic REG_STRIDE_ALIGN = 1'b0;
  localparam logic REG_LAYER_ALIGN  = 1'b1;

  localparam logic [6:0]  STRIDE_ALIGN_RST = 7'd16;
  localparam logic [16:0] LAYER_ALIGN_RST  = 17'd4096;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [15:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic        short_op;  // dividend below 2^16
    logic [63:0] num;
    logic [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [16:0] rem;
  } div_rsp_t;

  // next power of two, zero maps to one
  function automatic logic [15:0] pow2_up(logic [15:0] x);
    logic [15:0] y;
    y = x - 16'd1;
    y = y | (y >> 1);
    y = y | (y >> 2);
    y = y | (y >> 4);
    y = y | (y >> 8);
    if (x == 16'd0) pow2_up = 16'd1;
    else pow2_up = y + 16'd1;
  endfunction

  // round up to a multiple of 4 when enabled
  function automatic logic [15:0] round4(logic [15:0] x, logic en);
    logic [15:0] s;
    s = x + 16'd3;
    if (en) round4 = {s[15:2], 2'b00};
    else round4 = x;
  endfunction

  function automatic logic [15:0] halve(logic [15:0] x);
    logic [15:0] s;
    s = x >> 1;
    if (s == 16'd0) halve = 16'd1;
    else halve = s;
  endfunction

endpackage

// ===== hw/rtl/texture_mip_layout_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_mip_layout_calculator
// Mip level pitches, sizes and offsets of one image, one result per level.
// ----------------------------------------------------------------------------
// Usage:
//   An image descriptor is taken on in_valid while in_stall is low. One word
//   per mip level then leaves on the out channel, in level order; the final
//   level's word has last set and carries layer_bytes and image_bytes.
//   in_stall stays high from acceptance until the final word is loaded into
//   the output register; the next image may be taken while that word waits.
// Structure:
//   A small sequencer drives one shared 64x16 multiplier, which adds the
//   upper partial product only when the a operand has upper bits set, and
//   one radix-4 divider, which runs a short pass for extents and a full
//   pass for layer alignment. Per image it runs setup, then each mip level,
//   each padding level of the chain, array layer alignment and the image size.
// Reset:
//   rst clears the sequencer and the output valid, and loads stride_align 16
//   and layer_align 4096. Configuration is to be written through cfg_write
//   only while the block is idle; the block itself does not enforce this.
// Back-pressure:
//   The output register holds while out_stall is high; the sequencer waits
//   before each level word until the register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module texture_mip_layout_calculator
  import tmlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [14:0] width,
  input  logic [14:0] height,
  input  logic [11:0] depth,
  input  logic [3:0]  mip_count,
  input  logic [11:0] layer_count,
  input  logic [4:0]  sample_count,
  input  logic [4:0]  bytes_per_block,
  input  logic [3:0]  block_width,
  input  logic [3:0]  block_height,
  input  logic        is_3d,
  input  logic        tiling_optimal,
  input  logic [1:0]  scanout_or_target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  level_index,
  output logic [18:0] row_pitch,
  output logic [14:0] rows_pitch,
  output logic [62:0] level_bytes,
  output logic [62:0] level_offset,
  output logic [62:0] layer_bytes,
  output logic [62:0] image_bytes,
  output logic        last
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_STRIDE, S_CEILW, S_CEILH, S_SC, S_PITCH,
    S_SZ1, S_SZ2, S_SZ3, S_ACC, S_PCHK, S_ALIGN, S_IMG
  } state_t;

  state_t state;

  logic [6:0]  stride_align;
  logic [16:0] layer_align;

  logic [15:0] cur_w;
  logic [15:0] cur_h;
  logic [12:0] cur_d;
  logic [3:0]  levels;
  logic [3:0]  lvl;
  logic [11:0] layers;
  logic [4:0]  samples;
  logic [4:0]  cpp;
  logic [3:0]  bw;
  logic [3:0]  bh;
  logic        is3d;
  logic        twiddled;
  logic        use_rt;
  logic        pad;
  logic        issued;
  logic [9:0]  sc;
  logic [19:0] pitch;
  logic [63:0] size;
  logic [63:0] layer;

  logic [15:0] w4;
  logic [15:0] h4;
  logic [15:0] d4_full;
  logic [12:0] d4;
  logic [15:0] d_pow2;
  logic [15:0] d_half;
  logic [16:0] stride_sum;
  logic [16:0] ceilw_sum;
  logic [16:0] ceilh_sum;
  logic [63:0] align_sum;
  logic        is_last;
  logic        out_free;
  logic        need_pad;
  logic        need_align;
  logic [3:0]  levels_in;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  tmlc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  tmlc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign w4         = round4(cur_w, is3d);
  assign h4         = round4(cur_h, is3d);
  assign d4_full    = round4({3'd0, cur_d}, is3d);
  assign d4         = d4_full[12:0];
  assign d_pow2     = pow2_up({3'd0, cur_d});
  assign d_half     = halve({3'd0, cur_d});
  assign stride_sum = {1'b0, cur_w} + {10'd0, stride_align} - 17'd1;
  assign ceilw_sum  = {1'b0, cur_w} + {13'd0, bw} - 17'd1;
  assign ceilh_sum  = {1'b0, cur_h} + {13'd0, bh} - 17'd1;
  assign align_sum  = layer + {47'd0, layer_align} - 64'd1;
  assign is_last    = (lvl == levels - 4'd1);
  assign out_free   = !out_valid || !out_stall;
  assign need_pad   = (levels > 4'd1) &&
                      !((cur_w == 16'd1) && (cur_h == 16'd1) && (cur_d == 13'd1));
  assign need_align = (layers > 12'd1) && (layer_align != 17'd0);

  always_comb begin
    if (mip_count == 4'd0) levels_in = 4'd1;
    else if (mip_count > MAX_LEVELS) levels_in = MAX_LEVELS;
    else levels_in = mip_count;
  end

  assign in_stall = rst || (state != S_IDLE);

  // operand select for the shared units
  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state)
      S_STRIDE: begin
        div_req.start    = !issued;
        div_req.short_op = 1'b1;
        div_req.num      = {47'd0, stride_sum};
        div_req.den      = {10'd0, stride_align};
      end
      S_CEILW: begin
        div_req.start    = !issued;
        div_req.short_op = 1'b1;
        div_req.num      = {47'd0, ceilw_sum};
        div_req.den      = {13'd0, bw};
      end
      S_CEILH: begin
        div_req.start    = !issued;
        div_req.short_op = 1'b1;
        div_req.num      = {47'd0, ceilh_sum};
        div_req.den      = {13'd0, bh};
      end
      S_ALIGN: begin
        div_req.start = !issued && need_align;
        div_req.num   = align_sum;
        div_req.den   = layer_align;
      end
      S_SC: begin
        mul_req.start = !issued;
        mul_req.a     = {59'd0, cpp};
        mul_req.b     = {11'd0, samples};
      end
      S_PITCH: begin
        mul_req.start = !issued;
        mul_req.a     = {48'd0, w4};
        mul_req.b     = {11'd0, cpp};
      end
      S_SZ1: begin
        mul_req.start = !issued;
        mul_req.a     = {54'd0, sc};
        mul_req.b     = w4;
      end
      S_SZ2: begin
        mul_req.start = !issued;
        mul_req.a     = size;
        mul_req.b     = h4;
      end
      S_SZ3: begin
        mul_req.start = !issued;
        mul_req.a     = size;
        mul_req.b     = {3'd0, d4};
      end
      S_IMG: begin
        mul_req.start = !issued;
        mul_req.a     = layer;
        mul_req.b     = {4'd0, layers};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      issued       <= 1'b0;
      out_valid    <= 1'b0;
      stride_align <= STRIDE_ALIGN_RST;
      layer_align  <= LAYER_ALIGN_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STRIDE_ALIGN: stride_align <= cfg_data[6:0];
          REG_LAYER_ALIGN:  layer_align  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (mul_req.start || div_req.start) issued <= 1'b1;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_w    <= {1'b0, width};
            cur_h    <= {1'b0, height};
            cur_d    <= {1'b0, depth};
            levels   <= levels_in;
            layers   <= layer_count;
            samples  <= sample_count;
            cpp      <= bytes_per_block;
            bw       <= (block_width == 4'd0) ? 4'd1 : block_width;
            bh       <= (block_height == 4'd0) ? 4'd1 : block_height;
            is3d     <= is_3d;
            twiddled <= tiling_optimal && !scanout_or_target[0];
            use_rt   <= scanout_or_target[1];
            layer    <= 64'd0;
            lvl      <= 4'd0;
            pad      <= 1'b0;
            state    <= S_PREP;
          end
        end
        S_PREP: begin
          if ((levels > 4'd1) || twiddled) begin
            cur_w <= pow2_up(cur_w);
            cur_h <= pow2_up(cur_h);
            cur_d <= d_pow2[12:0];
            state <= S_CEILW;
          end else if (use_rt && (stride_align != 7'd0)) begin
            state <= S_STRIDE;
          end else begin
            state <= S_CEILW;
          end
        end
        S_STRIDE: begin
          if (div_rsp.done) begin
            cur_w  <= stride_sum[15:0] - div_rsp.rem[15:0];
            issued <= 1'b0;
            state  <= S_CEILW;
          end
        end
        S_CEILW: begin
          if (div_rsp.done) begin
            cur_w  <= div_rsp.quo[15:0];
            issued <= 1'b0;
            state  <= S_CEILH;
          end
        end
        S_CEILH: begin
          if (div_rsp.done) begin
            cur_h  <= div_rsp.quo[15:0];
            issued <= 1'b0;
            state  <= S_SC;
          end
        end
        S_SC: begin
          if (mul_rsp.done) begin
            sc     <= mul_rsp.p[9:0];
            issued <= 1'b0;
            state  <= S_PITCH;
          end
        end
        S_PITCH: begin
          if (mul_rsp.done) begin
            pitch  <= mul_rsp.p[19:0];
            issued <= 1'b0;
            state  <= S_SZ1;
          end
        end
        S_SZ1: begin
          if (mul_rsp.done) begin
            size   <= mul_rsp.p;
            issued <= 1'b0;
            state  <= S_SZ2;
          end
        end
        S_SZ2: begin
          if (mul_rsp.done) begin
            size   <= mul_rsp.p;
            issued <= 1'b0;
            state  <= S_SZ3;
          end
        end
        S_SZ3: begin
          if (mul_rsp.done) begin
            issued <= 1'b0;
            if (pad) begin
              // chain padding level: only adds to the layer
              layer <= layer + mul_rsp.p;
              cur_w <= halve(cur_w);
              cur_h <= halve(cur_h);
              cur_d <= d_half[12:0];
              state <= S_PCHK;
            end else begin
              size  <= mul_rsp.p;
              state <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (out_free) begin
            level_index  <= lvl;
            row_pitch    <= pitch[18:0];
            rows_pitch   <= h4[14:0];
            level_bytes  <= size[62:0];
            level_offset <= layer[62:0];
            layer_bytes  <= 63'd0;
            image_bytes  <= 63'd0;
            last         <= 1'b0;
            // final level word is held back until the layer size is known
            out_valid    <= !is_last;
            layer        <= layer + size;
            cur_w        <= halve(cur_w);
            cur_h        <= halve(cur_h);
            cur_d        <= d_half[12:0];
            if (is_last) begin
              pad   <= 1'b1;
              state <= S_PCHK;
            end else begin
              lvl   <= lvl + 4'd1;
              state <= S_PITCH;
            end
          end
        end
        S_PCHK: begin
          if (need_pad) state <= S_SZ1;
          else state <= S_ALIGN;
        end
        S_ALIGN: begin
          if (!need_align) begin
            state <= S_IMG;
          end else if (div_rsp.done) begin
            layer  <= align_sum - {47'd0, div_rsp.rem};
            issued <= 1'b0;
            state  <= S_IMG;
          end
        end
        S_IMG: begin
          if (mul_rsp.done) begin
            layer_bytes <= layer[62:0];
            image_bytes <= mul_rsp.p[62:0];
            last        <= 1'b1;
            out_valid   <= 1'b1;
            issued      <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_mul_done_issued, clk, rst, mul_rsp.done, issued)
  `ASSERT_IMPL(a_div_done_issued, clk, rst, div_rsp.done, issued)
  `ASSERT_IMPL(a_div_den_nonzero, clk, rst, div_req.start, div_req.den != 17'd0)
  `ASSERT_IMPL(a_level_in_range, clk, rst, out_valid && !last,
               ({1'b0, level_index} + 5'd1) < {1'b0, levels})

endmodule

// ===== hw/rtl/tmlc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlc_mul
// Shared 64x16 multiplier, modulo 2^64, one 32x16 partial product per cycle.
// ----------------------------------------------------------------------------
module tmlc_mul
  import tmlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [31:0] a_hi;
  logic [15:0] b_q;
  logic [63:0] acc;
  logic        busy;
  logic        done;
  logic [47:0] lo_prod;
  logic [47:0] hi_prod;

  assign lo_prod = req.a[31:0] * req.b;
  assign hi_prod = a_hi * b_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_hi <= req.a[63:32];
        b_q  <= req.b;
        acc  <= {16'd0, lo_prod};
        // upper half only when it holds anything
        if (req.a[63:32] == 32'd0) done <= 1'b1;
        else busy <= 1'b1;
      end else if (busy) begin
        acc  <= acc + {hi_prod[31:0], 32'd0};
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;

endmodule

// ===== hw/rtl/tmlc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlc_div
// Restoring divider, 64-bit dividend by 17-bit divisor, two bits per cycle.
// ----------------------------------------------------------------------------
module tmlc_div
  import tmlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [4:0] LAST_FULL  = 5'd31;
  localparam logic [4:0] LAST_SHORT = 5'd7;

  logic [63:0] num;   // dividend shifts out the top, quotient in at the bottom
  logic [16:0] rem;
  logic [16:0] den;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [17:0] s1;
  logic [17:0] s2;

  // {quotient bit, new remainder}
  function automatic logic [17:0] div_step(logic [16:0] r, logic b_in, logic [16:0] dv);
    logic [17:0] x;
    logic [17:0] diff;
    x    = {r, b_in};
    diff = x - {1'b0, dv};
    if (x >= {1'b0, dv}) div_step = {1'b1, diff[16:0]};
    else div_step = {1'b0, x[16:0]};
  endfunction

  assign s1 = div_step(rem, num[63], den);
  assign s2 = div_step(s1[16:0], num[62], den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        den  <= req.den;
        rem  <= 17'd0;
        busy <= 1'b1;
        if (req.short_op) begin
          num <= {req.num[15:0], 48'd0};
          cnt <= LAST_SHORT;
        end else begin
          num <= req.num;
          cnt <= LAST_FULL;
        end
      end else if (busy) begin
        num <= {num[61:0], s1[17], s2[17]};
        rem <= s2[16:0];
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = num;
  assign rsp.rem  = rem;

endmodule
